// ===== rtl/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared constants and types of the LZSS ring-window decompressor: window
// geometry, token format, ring access request and controller states.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int WIN_BITS     = $clog2(WINDOW_DEPTH);
    localparam int MATCH_MAX    = 17;
    localparam int MATCH_MIN    = 2;
    localparam int COUNT_BITS   = 24;
    localparam int CNT_BITS     = 4;
    localparam int BYTE_BITS    = 8;
    // longest run of unconsumed stream bits between input bytes
    localparam int HOLD_MAX     = 12;
    localparam int HOLD_BITS    = 4;
    localparam int BUF_BITS     = HOLD_MAX;
    localparam int FULL_BITS    = BUF_BITS + BYTE_BITS;
    localparam int REMAIN_BITS  = $clog2(MATCH_MAX + 1);
    localparam int FILL_BITS    = WIN_BITS + 1;

    localparam logic [WIN_BITS-1:0] INIT_POS = WIN_BITS'(WINDOW_DEPTH - MATCH_MAX);

    typedef logic [BYTE_BITS-1:0]  byte_t;
    typedef logic [WIN_BITS-1:0]   win_addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_LIT,
        TOK_COPY
    } tok_kind_t;

    // data carries the literal byte or the copy source position
    typedef struct packed {
        tok_kind_t           kind;
        byte_t               data;
        logic [CNT_BITS-1:0] cnt;
    } token_t;

    typedef struct packed {
        logic      rd_en;
        win_addr_t rd_addr;
        logic      wr_en;
        win_addr_t wr_addr;
        byte_t     wr_data;
    } ring_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIT,
        ST_COPY
    } state_t;

endpackage

// ===== rtl/lzss_ring_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_ring_decompressor
// LZSS decoder with a 256-byte ring window: literal and copy tokens from an
// MSB-first bit stream, output stops at a programmable byte count.
// ----------------------------------------------------------------------------
// Each accepted compressed byte completes no token, completes a literal that
// ST_LIT emits, or completes a copy of cnt+2 bytes (2 to 17): ST_IDLE issues
// the first ring read, then ST_COPY emits one output byte per cycle while the
// output slot is free, as the sequencer streams reads and write-backs through
// the single-port-per-direction ring memory. Output back-pressure stalls the
// sequencer. Once output_limit bytes are produced, input bytes are taken
// and ignored until the limit is raised. The ring reads as
// zero until written; no clearing pass is needed after reset.
module lzss_ring_decompressor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lzsd_pkg::COUNT_BITS-1:0] cfg_wr_data,   // output_limit
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
    input  logic                           s_axis_tlast,   // last_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
    output logic                           m_axis_tlast,   // out_last
    output logic                           m_axis_tuser    // [0] done_res
);
    import lzsd_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    byte_t                  lit_reg;
    byte_t                  lit_next;
    win_addr_t              rd_pos_reg;
    win_addr_t              rd_pos_next;
    logic [REMAIN_BITS-1:0] remain_reg;
    logic [REMAIN_BITS-1:0] remain_next;
    win_addr_t              wpos_reg;
    win_addr_t              wpos_next;
    count_t                 bytes_out_reg;
    count_t                 bytes_out_next;
    count_t                 limit_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    byte_t                  out_byte_reg;
    byte_t                  out_byte_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    logic                   out_done_reg;
    logic                   out_done_next;

    token_t                 token;
    ring_req_t              ring_req;
    byte_t                  ring_data;
    logic                   accept;
    logic                   running;
    logic                   slot_free;
    logic                   emit;
    byte_t                  emit_byte;
    logic                   emit_last;
    count_t                 bytes_inc;
    logic                   done_now;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign running       = bytes_out_reg < limit_reg;
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign bytes_inc     = bytes_out_reg + 1'b1;
    assign done_now      = bytes_inc >= limit_reg;

    lzsd_unpack u_unpack (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept && running),
        .in_byte (s_axis_tdata),
        .last_in (s_axis_tlast),
        .token   (token)
    );

    lzsd_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .rd_data (ring_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        lit_next       = lit_reg;
        rd_pos_next    = rd_pos_reg;
        remain_next    = remain_reg;
        emit           = 1'b0;
        emit_byte      = lit_reg;
        emit_last      = 1'b1;
        ring_req.rd_en   = 1'b0;
        ring_req.rd_addr = rd_pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && running)
                begin
                    case (token.kind)
                        TOK_LIT:
                        begin
                            lit_next   = token.data;
                            state_next = ST_LIT;
                        end
                        TOK_COPY:
                        begin
                            ring_req.rd_en   = 1'b1;
                            ring_req.rd_addr = token.data;
                            rd_pos_next      = token.data + 1'b1;
                            remain_next      = REMAIN_BITS'(token.cnt) +
                                               REMAIN_BITS'(MATCH_MIN);
                            state_next       = ST_COPY;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LIT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                emit_byte = ring_data;
                emit_last = (remain_reg == REMAIN_BITS'(1)) || done_now;
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // issue the next read while this byte is written back
                        ring_req.rd_en = 1'b1;
                        rd_pos_next    = rd_pos_reg + 1'b1;
                        remain_next    = remain_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ring_req.wr_en   = emit;
        ring_req.wr_addr = wpos_reg;
        ring_req.wr_data = emit_byte;

        wpos_next      = emit ? wpos_reg + 1'b1 : wpos_reg;
        bytes_out_next = emit ? bytes_inc : bytes_out_reg;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
            out_done_next  = done_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            wpos_reg      <= INIT_POS;
            bytes_out_reg <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            wpos_reg      <= wpos_next;
            bytes_out_reg <= bytes_out_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg      <= lit_next;
        rd_pos_reg   <= rd_pos_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

`ifndef SYNTHESIS
    a_count_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        ring_req.wr_en |=> bytes_out_reg == COUNT_BITS'($past(bytes_out_reg) + 1'b1))
        else $error("output count did not advance with a ring write");

    a_wpos_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        ring_req.wr_en |=> wpos_reg == WIN_BITS'($past(wpos_reg) + 1'b1))
        else $error("write pointer did not advance with a ring write");

    a_copy_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY |-> (remain_reg != '0) &&
                                 (remain_reg <= REMAIN_BITS'(MATCH_MAX)))
        else $error("copy length out of range");

    a_done_ends_token: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && done_now) |=> (state_reg == ST_IDLE) && m_axis_tlast)
        else $error("decoding continued past the output limit");
`endif

endmodule

// ===== rtl/lzsd_ring.sv =====
// ----------------------------------------------------------------------------
// lzsd_ring
// 256-byte history ring with a registered read. Forwards a write that
// lands on the address read in the same cycle, and returns zero for entries
// not yet written since reset, tracked by a fill count from the initial
// write position.
// ----------------------------------------------------------------------------
module lzsd_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  lzsd_pkg::ring_req_t req,
    output lzsd_pkg::byte_t    rd_data
);
    import lzsd_pkg::*;

    byte_t                 mem [WINDOW_DEPTH];
    byte_t                 raw_reg;
    byte_t                 fwd_data_reg;
    logic                  fwd_hit_reg;
    logic                  fresh_reg;
    logic [FILL_BITS-1:0]  fill_reg;
    logic [FILL_BITS-1:0]  fill_next;
    win_addr_t             rd_offset;
    logic                  rd_written;

    // writes run in sequence from INIT_POS, so written entries form one span
    assign rd_offset  = req.rd_addr - INIT_POS;
    assign rd_written = {1'b0, rd_offset} < fill_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (req.wr_en && (fill_reg < FILL_BITS'(WINDOW_DEPTH)))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            raw_reg      <= mem[req.rd_addr];
            fwd_data_reg <= req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            fwd_hit_reg <= 1'b0;
            fresh_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            // hold the read result until the next read is issued
            if (req.rd_en)
            begin
                fwd_hit_reg <= req.wr_en && (req.wr_addr == req.rd_addr);
                fresh_reg   <= rd_written;
            end
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : (fresh_reg ? raw_reg : '0);

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(WINDOW_DEPTH))
        else $error("ring fill count overran the ring depth");
`endif

endmodule

// ===== rtl/lzsd_unpack.sv =====
// ----------------------------------------------------------------------------
// lzsd_unpack
// MSB-first bit unpacker. Appends each accepted byte to the held stream bits,
// decodes at most one literal or copy token and keeps the remaining bits.
// ----------------------------------------------------------------------------
module lzsd_unpack (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lzsd_pkg::byte_t  in_byte,
    input  logic             last_in,
    output lzsd_pkg::token_t token
);
    import lzsd_pkg::*;

    logic [BUF_BITS-1:0]  buf_reg;
    logic [BUF_BITS-1:0]  buf_next;
    logic [HOLD_BITS-1:0] held_reg;
    logic [HOLD_BITS-1:0] held_next;
    logic [FULL_BITS-1:0] full;
    logic [FULL_BITS-1:0] aligned;
    logic [4:0]           avail;
    logic [4:0]           left;
    logic                 flag;

    always_comb
    begin
        avail   = 5'(held_reg) + 5'(BYTE_BITS);
        full    = {buf_reg, in_byte};
        // left-align so the flag sits in the top bit
        aligned = full << (5'(FULL_BITS) - avail);
        flag    = aligned[FULL_BITS-1];

        token.data = aligned[FULL_BITS-2 -: BYTE_BITS];
        token.cnt  = aligned[FULL_BITS-2-BYTE_BITS -: CNT_BITS];
        token.kind = TOK_NONE;
        left       = avail;
        if (flag && (avail >= 5'(1 + BYTE_BITS)))
        begin
            token.kind = TOK_LIT;
            left       = avail - 5'(1 + BYTE_BITS);
        end
        else if (!flag && (avail >= 5'(1 + BYTE_BITS + CNT_BITS)))
        begin
            token.kind = TOK_COPY;
            left       = avail - 5'(1 + BYTE_BITS + CNT_BITS);
        end

        buf_next  = full[BUF_BITS-1:0] & ~({BUF_BITS{1'b1}} << left);
        held_next = left[HOLD_BITS-1:0];
        // drop a partial token at the end of the stream
        if (last_in)
        begin
            buf_next  = '0;
            held_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            held_reg <= '0;
        end
        else if (load)
        begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
        end
    end

`ifndef SYNTHESIS
    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HOLD_BITS'(HOLD_MAX))
        else $error("unpacker holds more bits than one partial token");
`endif

endmodule
